>>> rtl/chfr_pkg.sv
// Package for the CRC-8 checked hit-frame receiver.
// Holds the item and result types, the CRC-8 byte update and the stream widths.
// No dependencies.
`default_nettype none

package chfr_pkg;

  // CRC-8 polynomial x^8 + x^2 + x + 1, unreflected, init zero, no final xor.
  localparam logic [7:0] CrcPoly = 8'h07;

  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutTdataW = 24;

  typedef enum logic {
    KindRxByte   = 1'b0,
    KindHostRead = 1'b1
  } chfr_kind_e;

  typedef struct packed {
    chfr_kind_e  kind;
    logic [7:0]  rx_byte;
  } chfr_item_t;

  typedef struct packed {
    logic        frame_accepted;
    logic [7:0]  damage;
    logic [7:0]  player_id;
    logic        hit_pending;
  } chfr_result_t;

  // Shifts one byte through the CRC register, most significant bit first.
  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/chfr_crc8.sv
// CRC-8 over the two older bytes of the receive window.
// Depends on chfr_pkg for the byte update function.
`default_nettype none

module chfr_crc8 (
  input  logic [7:0] older_i,
  input  logic [7:0] newer_i,
  output logic [7:0] crc_o
);
  import chfr_pkg::*;

  logic [7:0] crc_first;

  // The register starts at zero, so the first byte enters it directly.
  assign crc_first = crc8_update(8'h00, older_i);
  assign crc_o     = crc8_update(crc_first, newer_i);

endmodule

`default_nettype wire

>>> rtl/chfr_hit_state.sv
// Receive window, CRC compare and latched hit state.
// Depends on chfr_pkg and chfr_crc8.
`default_nettype none

module chfr_hit_state (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_valid_i,
  input  chfr_pkg::chfr_item_t  step_item_i,
  output chfr_pkg::chfr_result_t result_o
);
  import chfr_pkg::*;

  logic [7:0] older_q, older_d;
  logic [7:0] newer_q, newer_d;
  logic       pending_q, pending_d;
  logic [7:0] latched_player_q, latched_player_d;
  logic [7:0] latched_damage_q, latched_damage_d;
  logic [7:0] crc;
  logic       is_byte;
  logic       match;

  chfr_crc8 u_crc8 (
    .older_i (older_q),
    .newer_i (newer_q),
    .crc_o   (crc)
  );

  assign is_byte = (step_item_i.kind == KindRxByte);
  assign match   = is_byte && (crc == step_item_i.rx_byte);

  always_comb begin
    older_d          = older_q;
    newer_d          = newer_q;
    pending_d        = pending_q;
    latched_player_d = latched_player_q;
    latched_damage_d = latched_damage_q;
    if (step_valid_i) begin
      if (is_byte) begin
        if (match) begin
          latched_player_d = older_q;
          latched_damage_d = newer_q;
          pending_d        = 1'b1;
        end
        older_d = newer_q;
        newer_d = step_item_i.rx_byte;
      end else begin
        pending_d = 1'b0;
      end
    end
  end

  // A byte reports the flag after the update, a host read the flag before clearing.
  always_comb begin
    result_o.hit_pending    = is_byte ? (pending_q | match) : pending_q;
    result_o.player_id      = match ? older_q : latched_player_q;
    result_o.damage         = match ? newer_q : latched_damage_q;
    result_o.frame_accepted = match;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q          <= 8'h00;
      newer_q          <= 8'h00;
      pending_q        <= 1'b0;
      latched_player_q <= 8'h00;
      latched_damage_q <= 8'h00;
    end else begin
      older_q          <= older_d;
      newer_q          <= newer_d;
      pending_q        <= pending_d;
      latched_player_q <= latched_player_d;
      latched_damage_q <= latched_damage_d;
    end
  end

  a_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_valid_i && !is_byte |=> !pending_q)
    else $error("pending flag not cleared by host read");

  a_read_keeps_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_valid_i && !is_byte |=> older_q == $past(older_q) && newer_q == $past(newer_q))
    else $error("host read disturbed the receive window");

  a_match_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_valid_i && match |=> pending_q && latched_player_q == $past(older_q)
                              && latched_damage_q == $past(newer_q))
    else $error("accepted frame not latched");

  a_accept_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.frame_accepted |-> result_o.hit_pending)
    else $error("accepted frame reported without pending hit");

endmodule

`default_nettype wire

>>> rtl/crc8_checked_hit_frame_receiver.sv
// Top level of the CRC-8 checked hit-frame receiver: stream ports, input
// register and result register. Depends on chfr_pkg and chfr_hit_state.
`default_nettype none

// The receiver takes one transaction per clock cycle on the slave stream and
// returns exactly one result transaction per input, in order, on the master
// stream. A transaction with tuser low carries a received serial byte: the block
// keeps the two bytes before it, computes CRC-8 (polynomial 0x07, init zero,
// unreflected, no final xor) over them and, when the CRC equals the new byte,
// latches them as player id and damage and sets the pending-hit flag. A
// transaction with tuser high reports the latched hit and then clears the flag.
// After reset the window holds zeros, so a first zero byte already counts as a
// valid frame with player 0 and damage 0. Each item sits first in the input
// register, where the CRC compare and the state update happen, and then in
// the result register, which drives tvalid on the master side. Sustained
// throughput is one transaction per cycle while the master side accepts,
// through the combinational CRC path between the two registers. Backpressure
// on the master side stalls both registers; s_axis_tready_o stays high as
// long as the input register is empty or the result register is empty or
// being drained.
module crc8_checked_hit_frame_receiver (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [7:0] rx_byte
  input  logic [chfr_pkg::InTdataW-1:0]   s_axis_tdata_i,
  // [0] kind (0 = serial byte, 1 = host read)
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [0] hit_pending, [8:1] player_id, [16:9] damage, [17] frame_accepted,
  // [23:18] zero
  output logic [chfr_pkg::OutTdataW-1:0]  m_axis_tdata_o
);
  import chfr_pkg::*;

  logic         in_valid_q, in_valid_d;
  chfr_item_t   in_item_q;
  logic         out_valid_q, out_valid_d;
  chfr_result_t out_result_q;
  chfr_result_t step_result;
  logic         advance;
  logic         step_valid;
  logic         in_load;

  // The result register frees up when it is empty or its transaction completes.
  assign advance    = !out_valid_q || m_axis_tready_i;
  assign step_valid = in_valid_q && advance;

  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_load         = s_axis_tvalid_i && s_axis_tready_o;

  chfr_hit_state u_hit_state (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_valid_i (step_valid),
    .step_item_i  (in_item_q),
    .result_o     (step_result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready_o) begin
      in_valid_d = s_axis_tvalid_i;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_item_q.kind    <= chfr_kind_e'(s_axis_tuser_i);
      in_item_q.rx_byte <= s_axis_tdata_i[7:0];
    end
    if (step_valid) begin
      out_result_q <= step_result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutTdataW - $bits(chfr_result_t)){1'b0}}, out_result_q};

endmodule

`default_nettype wire
